// ===== rtl/core/g2u_pkg.sv =====
package g2u_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH_DEF = 24066;
  localparam int unsigned IDX_W           = 16;

  // GBK byte ranges
  localparam logic [7:0] LEAD_MIN    = 8'h81;
  localparam logic [7:0] TRAIL_MIN   = 8'h40;
  localparam logic [7:0] BYTE_BAD    = 8'hFF;
  localparam logic [7:0] LEAD_STRIDE = 8'hBF;

  // UTF-8 three-byte framing
  localparam logic [3:0] UTF8_LEAD3 = 4'hE;
  localparam logic [1:0] UTF8_CONT  = 2'b10;

  typedef enum logic {
    OP_CONVERT  = 1'b0,
    OP_TABLE_WR = 1'b1
  } opcode_t;

  // Emitter states
  typedef enum logic [2:0] {
    EM_IDLE,
    EM_PLAIN,
    EM_B0,
    EM_B1,
    EM_B2
  } emit_state_t;

  // Item parked between the decode stage and the emitter
  typedef struct packed {
    logic       valid;
    logic       pair;   // 1: table lookup, 0: plain byte
    logic       ok;     // pair in range, table read issued
    logic [7:0] data;   // plain byte value
  } g2u_item_t;

endpackage

// ===== rtl/core/g2u_if.sv =====
interface g2u_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  data_byte;
  logic        end_of_text;
  logic [14:0] table_index;
  logic [15:0] table_value;

  modport source (
    output valid, opcode, data_byte, end_of_text, table_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, data_byte, end_of_text, table_index, table_value,
    output ready
  );
endinterface

interface g2u_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (
    output valid, out_byte, run_last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, run_last,
    output ready
  );
endinterface

// ===== rtl/core/g2u_table.sv =====
module g2u_table
  import g2u_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data_r
);

  logic [15:0] mem [TABLE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/g2u_front.sv =====
module g2u_front
  import g2u_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  g2u_in_if.sink        in_ch,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [15:0]   wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output g2u_item_t     item_r,
  input  logic          item_take
);

  localparam logic [IDX_W-1:0] DEPTH_W = IDX_W'(TABLE_DEPTH);

  logic             lead_pending_r, lead_pending_nxt;
  logic             lead_ok_r, lead_ok_nxt;
  logic [14:0]      lead_base_r, lead_base_nxt;
  g2u_item_t        item_nxt;
  logic             accept;
  logic             is_conv;
  logic [6:0]       lead_off;
  logic [IDX_W-1:0] pair_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             trail_ok;
  logic             pair_ok;

  // Take a new transfer when the parked item is empty or leaves this cycle
  assign in_ch.ready = !item_r.valid || item_take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_conv     = (opcode_t'(in_ch.opcode) == OP_CONVERT);

  // Table write; a write lands before any later trail reads it
  assign wr_idx  = {1'b0, in_ch.table_index};
  assign wr_en   = accept && !is_conv && (wr_idx < DEPTH_W);
  assign wr_addr = in_ch.table_index[AW-1:0];
  assign wr_data = in_ch.table_value;

  // Row offset of a lead byte, computed once when the lead arrives
  assign lead_off = in_ch.data_byte[6:0] - LEAD_MIN[6:0];

  // Pair index from the stored row offset
  assign pair_idx = {1'b0, lead_base_r} + IDX_W'(in_ch.data_byte - TRAIL_MIN);
  assign trail_ok = (in_ch.data_byte >= TRAIL_MIN) && (in_ch.data_byte != BYTE_BAD);
  assign pair_ok  = lead_ok_r && trail_ok && (pair_idx < DEPTH_W);

  assign rd_en   = accept && is_conv && lead_pending_r && pair_ok;
  assign rd_addr = pair_idx[AW-1:0];

  // Decode accepted items
  always_comb begin
    lead_pending_nxt = lead_pending_r;
    lead_ok_nxt      = lead_ok_r;
    lead_base_nxt    = lead_base_r;
    item_nxt         = item_r;
    if (item_take) begin
      item_nxt.valid = 1'b0;
    end
    if (accept && is_conv) begin
      if (lead_pending_r) begin
        lead_pending_nxt = 1'b0;
        item_nxt.valid   = 1'b1;
        item_nxt.pair    = 1'b1;
        item_nxt.ok      = pair_ok;
        item_nxt.data    = in_ch.data_byte;
      end else if (in_ch.data_byte[7]) begin
        lead_pending_nxt = !in_ch.end_of_text;
        lead_ok_nxt      = (in_ch.data_byte >= LEAD_MIN) && (in_ch.data_byte != BYTE_BAD);
        lead_base_nxt    = 15'(15'(lead_off) * 15'(LEAD_STRIDE));
      end else begin
        item_nxt.valid = 1'b1;
        item_nxt.pair  = 1'b0;
        item_nxt.ok    = 1'b0;
        item_nxt.data  = in_ch.data_byte;
      end
    end
  end

  // Lead and parked item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      lead_ok_r      <= 1'b0;
      lead_base_r    <= '0;
      item_r         <= '0;
    end else begin
      lead_pending_r <= lead_pending_nxt;
      lead_ok_r      <= lead_ok_nxt;
      lead_base_r    <= lead_base_nxt;
      item_r         <= item_nxt;
    end
  end

  // A parked item holds while the emitter is busy
  a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (item_r.valid && !item_take) |=> (item_r.valid && $stable(item_r)))
    else $error("parked item changed while stalled");

  // A table read always parks a pair item in the next cycle
  a_read_pair: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (item_r.valid && item_r.pair && item_r.ok))
    else $error("table read without pair item");

  // No read and write in the same cycle
  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("table read and write overlap");

endmodule

// ===== rtl/core/g2u_emit.sv =====
module g2u_emit
  import g2u_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  g2u_item_t   item,
  input  logic [15:0] rd_data,
  output logic        item_take,
  g2u_out_if.source   out_ch
);

  emit_state_t state_r, state_nxt, load_state;
  logic [15:0] code_r, code_nxt;
  logic [7:0]  plain_r, plain_nxt;
  logic        fire;
  logic        done;

  assign fire = out_ch.valid && out_ch.ready;
  assign done = (state_r == EM_IDLE) || (fire && out_ch.run_last);

  // Pull the parked item once the current run has gone out
  assign item_take = item.valid && done;

  // Where a taken item starts; empty lookups drop out here
  always_comb begin
    if (!item.pair) begin
      load_state = EM_PLAIN;
    end else if (item.ok && (rd_data != 16'h0000)) begin
      load_state = EM_B0;
    end else begin
      load_state = EM_IDLE;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (fire && !out_ch.run_last) begin
      unique case (state_r)
        EM_B0:   state_nxt = EM_B1;
        EM_B1:   state_nxt = EM_B2;
        default: state_nxt = state_r;
      endcase
    end
    if (done) begin
      state_nxt = item.valid ? load_state : EM_IDLE;
    end
  end

  // Payload capture
  always_comb begin
    code_nxt  = code_r;
    plain_nxt = plain_r;
    if (item_take) begin
      code_nxt  = rd_data;
      plain_nxt = item.data;
    end
  end

  // Outputs
  always_comb begin
    out_ch.valid    = 1'b1;
    out_ch.out_byte = plain_r;
    out_ch.run_last = 1'b0;
    unique case (state_r)
      EM_IDLE: begin
        out_ch.valid = 1'b0;
      end
      EM_PLAIN: begin
        out_ch.run_last = 1'b1;
      end
      EM_B0: begin
        out_ch.out_byte = {UTF8_LEAD3, code_r[15:12]};
      end
      EM_B1: begin
        out_ch.out_byte = {UTF8_CONT, code_r[11:6]};
      end
      EM_B2: begin
        out_ch.out_byte = {UTF8_CONT, code_r[5:0]};
        out_ch.run_last = 1'b1;
      end
      default: begin
        out_ch.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    plain_r <= plain_nxt;
  end

  // The last UTF-8 byte only follows the middle one
  a_b2_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EM_B2) |-> ($past(state_r) == EM_B1 || $past(state_r) == EM_B2))
    else $error("third byte out of sequence");

  // A finished run with nothing parked leaves the emitter empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_ch.run_last && !item.valid) |=> (state_r == EM_IDLE))
    else $error("emitter not empty after last byte");

  // A multi-byte code never starts with a zero code point
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EM_B0) |-> (code_r != 16'h0000))
    else $error("zero code point emitted");

endmodule

// ===== rtl/core/gbk_to_utf8_transcoder.sv =====
// Channel   Dir  Payload                                                  Transfer
// in_ch     in   opcode, data_byte, end_of_text, table_index, table_value  valid & ready
// out_ch    out  out_byte, run_last                                       valid & ready
//
// A plain byte passes the parked item register and the emitter state register and leaves as
// one byte; a mapped pair leaves the same way as three bytes, so an out_ch run is 1 to 3 bytes.
// Table writes, lead bytes and dropped pairs emit nothing.
// The code table is a single-port-write, registered-read memory read once per in-range pair.
// rst_n clears the lead flag and the pipeline; the table is not cleared.
// A stall on out_ch holds one parked item; input keeps flowing until it fills.
module gbk_to_utf8_transcoder
  import g2u_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  g2u_in_if.sink    in_ch,
  g2u_out_if.source out_ch
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  g2u_item_t     item;
  logic          item_take;

  g2u_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .item_r    (item),
    .item_take (item_take)
  );

  g2u_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  g2u_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .rd_data   (rd_data),
    .item_take (item_take),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/utf8_stream_checker.sv =====
module utf8_stream_checker
  import g2u_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  g2u_in_if    in_ch,
  g2u_out_if   out_ch,
  output int   fail_count,
  output int   bytes_owed
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } utf8_byte_t;

  // Shadow of the code table and the lead byte held for pairing
  bit [15:0]  code_mem [TABLE_DEPTH];
  bit         lead_held;
  bit [7:0]   lead_byte;
  utf8_byte_t owed_q[$];
  int         mismatches;
  int         out_count;

  // Table slot of a GBK pair, TABLE_DEPTH when the pair is out of range
  function automatic int unsigned table_slot(logic [7:0] lead, logic [7:0] trail);
    if (lead < LEAD_MIN || lead == BYTE_BAD || trail < TRAIL_MIN || trail == BYTE_BAD)
      return TABLE_DEPTH;
    return (int'(trail) - int'(TRAIL_MIN)) + (int'(lead) - int'(LEAD_MIN)) * int'(LEAD_STRIDE);
  endfunction

  // Queue one owed byte behind the others
  function automatic void owe_byte(logic [7:0] b, logic last);
    utf8_byte_t entry;
    entry.out_byte = b;
    entry.run_last = last;
    owed_q.insert(owed_q.size(), entry);
  endfunction

  // Work out the UTF-8 bytes owed for one input transfer
  task automatic predict_item(logic op, logic [7:0] gbk_byte, logic eot,
                              logic [14:0] idx, logic [15:0] val);
    int unsigned slot;
    bit [15:0]   cp;
    if (opcode_t'(op) == OP_TABLE_WR) begin
      if (idx < TABLE_DEPTH) code_mem[idx] = val;
    end else if (lead_held) begin
      // trail is consumed whatever its value
      lead_held = 1'b0;
      slot = table_slot(lead_byte, gbk_byte);
      if (slot < TABLE_DEPTH) begin
        cp = code_mem[slot];
        if (cp != 16'h0000) begin
          owe_byte({UTF8_LEAD3, cp[15:12]}, 1'b0);
          owe_byte({UTF8_CONT, cp[11:6]}, 1'b0);
          owe_byte({UTF8_CONT, cp[5:0]}, 1'b1);
        end
      end
    end else if (gbk_byte[7]) begin
      // a lead at end of text is dropped
      if (!eot) begin
        lead_held = 1'b1;
        lead_byte = gbk_byte;
      end
    end else begin
      owe_byte(gbk_byte, 1'b1);
    end
  endtask

  // Compare one output transfer against the oldest owed byte
  task automatic check_byte(logic [7:0] got_byte, logic got_last);
    utf8_byte_t want;
    if (owed_q.size() == 0) begin
      if (mismatches < 10)
        $display("out_ch transfer %0d: nothing owed, got byte %02h last %0b",
                 out_count, got_byte, got_last);
      mismatches++;
    end else begin
      want = owed_q.pop_front();
      if (got_byte !== want.out_byte || got_last !== want.run_last) begin
        if (mismatches < 10)
          $display("out_ch transfer %0d: expected byte %02h last %0b, got byte %02h last %0b",
                   out_count, want.out_byte, want.run_last, got_byte, got_last);
        mismatches++;
      end
    end
    out_count++;
  endtask

  // Sample both channels; drain the output side before adding new expectations
  always @(posedge clk) begin
    if (!rst_n) begin
      lead_held = 1'b0;
      lead_byte = 8'h00;
      owed_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_byte(out_ch.out_byte, out_ch.run_last);
      if (in_ch.valid && in_ch.ready)
        predict_item(in_ch.opcode, in_ch.data_byte, in_ch.end_of_text,
                     in_ch.table_index, in_ch.table_value);
    end
    bytes_owed <= owed_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import g2u_pkg::*;

  localparam int unsigned TABLE_DEPTH   = TABLE_DEPTH_DEF;
  localparam int          ITEM_TARGET   = 480;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          IDLE_PLAN[4]  = '{0, 77, 0, 24};
  localparam int          STALL_PLAN[4] = '{0, 0, 77, 24};

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   bytes_owed;
  int   cycle_count;
  int   send_idle_pct;
  int   stall_pct;
  int   items_sent;

  // Stimulus-side bookkeeping: which entries hold a value, and the open lead
  bit          entry_set [TABLE_DEPTH];
  int unsigned set_entries[$];
  bit          lead_open;
  bit [7:0]    lead_byte;

  g2u_in_if  in_ch ();
  g2u_out_if out_ch ();

  gbk_to_utf8_transcoder #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8_stream_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Random backpressure on the result channel
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("gbk_to_utf8_transcoder: mismatch");
      $finish;
    end
  end

  // Slot a GBK pair addresses, TABLE_DEPTH when out of range
  function automatic int unsigned gbk_slot(logic [7:0] lead, logic [7:0] trail);
    if (lead < LEAD_MIN || lead == BYTE_BAD || trail < TRAIL_MIN || trail == BYTE_BAD)
      return TABLE_DEPTH;
    return (int'(trail) - int'(TRAIL_MIN)) + (int'(lead) - int'(LEAD_MIN)) * int'(LEAD_STRIDE);
  endfunction

  // Code point with extra weight on unmapped and all-ones
  function automatic logic [15:0] code_point();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 16'h0000;
    if (pick < 15) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Drive one item, with random idle cycles ahead of it, and hold until the transfer
  task automatic transfer(opcode_t op, logic [7:0] gbk_byte, logic eot,
                          logic [14:0] idx, logic [15:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.data_byte   <= gbk_byte;
    in_ch.end_of_text <= eot;
    in_ch.table_index <= idx;
    in_ch.table_value <= val;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic write_entry(logic [14:0] idx, logic [15:0] val);
    transfer(OP_TABLE_WR, 8'($urandom), 1'($urandom), idx, val);
    if (idx < TABLE_DEPTH && !entry_set[idx]) begin
      entry_set[idx] = 1'b1;
      set_entries.insert(set_entries.size(), idx);
    end
  endtask

  // Send one GBK byte; fill the entry first if a valid pair would read a blank slot
  task automatic send_byte(logic [7:0] gbk_byte, logic eot);
    int unsigned slot;
    if (lead_open) begin
      slot = gbk_slot(lead_byte, gbk_byte);
      if (slot < TABLE_DEPTH && !entry_set[slot]) write_entry(15'(slot), code_point());
      lead_open = 1'b0;
    end else if (gbk_byte[7] && !eot) begin
      lead_open = 1'b1;
      lead_byte = gbk_byte;
    end
    transfer(OP_CONVERT, gbk_byte, eot, 15'($urandom), 16'($urandom));
  endtask

  // Hold the sender until every owed byte has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (bytes_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // One random sequence, well-formed pairs the most common kind
  task automatic random_sequence();
    int          pick;
    int unsigned slot;
    logic [7:0]  lead;
    logic [7:0]  trail;
    pick = $urandom_range(99);
    if (pick < 45) begin
      if (set_entries.size() != 0 && $urandom_range(99) < 30) begin
        slot = set_entries[$urandom_range(set_entries.size() - 1)];
      end else begin
        slot = $urandom_range(TABLE_DEPTH - 1);
        write_entry(15'(slot), code_point());
      end
      lead  = 8'(int'(LEAD_MIN) + slot / int'(LEAD_STRIDE));
      trail = 8'(int'(TRAIL_MIN) + slot % int'(LEAD_STRIDE));
      send_byte(lead, 1'b0);
      if ($urandom_range(9) == 0) write_entry(15'($urandom_range(32767)), code_point());
      send_byte(trail, $urandom_range(4) == 0);
    end else if (pick < 70) begin
      send_byte(8'($urandom_range(127)), $urandom_range(3) == 0);
    end else if (pick < 80) begin
      write_entry(15'($urandom_range(32767)), code_point());
    end else if (pick < 90) begin
      // broken pair: any lead, any trail
      send_byte(8'($urandom_range(255, 128)), 1'b0);
      send_byte(8'($urandom), $urandom_range(3) == 0);
    end else begin
      send_byte(8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_CONVERT;
    in_ch.data_byte   = 8'h00;
    in_ch.end_of_text = 1'b0;
    in_ch.table_index = 15'h0000;
    in_ch.table_value = 16'h0000;
    send_idle_pct     = 0;
    stall_pct         = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: table edges, unmapped entry, writes past the table
    write_entry(15'd0, 16'hFFFF);
    write_entry(15'(TABLE_DEPTH - 1), 16'h0001);
    write_entry(15'd5, 16'h0000);
    write_entry(15'(TABLE_DEPTH), 16'hAAAA);
    // plain bytes at both ends, one closing the text
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // lowest and highest pairs
    send_byte(8'h81, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFE, 1'b1);
    // pair landing on an unmapped entry
    send_byte(8'h81, 1'b0);
    send_byte(8'h45, 1'b0);
    // invalid pairs: lead too low, trail too low, lead and trail at 0xFF
    send_byte(8'h80, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h50, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'hFF, 1'b0);
    // lead dropped at end of text, then a plain byte
    send_byte(8'hC0, 1'b1);
    send_byte(8'h41, 1'b0);
    // table write between lead and trail
    send_byte(8'h81, 1'b0);
    write_entry(15'd0, 16'h0800);
    send_byte(8'h40, 1'b0);

    // Random part, one idling plan per phase, full drain at each phase end
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = IDLE_PLAN[phase];
      stall_pct     = STALL_PLAN[phase];
      while (items_sent < ITEM_TARGET * (phase + 1) / 4) random_sequence();
      drain();
    end

    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("gbk_to_utf8_transcoder: match");
    end else begin
      $display("gbk_to_utf8_transcoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/g2u_pkg.sv
rtl/core/g2u_if.sv
rtl/core/g2u_table.sv
rtl/core/g2u_front.sv
rtl/core/g2u_emit.sv
rtl/core/gbk_to_utf8_transcoder.sv
tb/utf8_stream_checker.sv
tb/testbench.sv
